[rtl/core/chlg_pkg.sv]
// Shared types, constants and microcode table of the core hotplug load governor.
package chlg_pkg;

  // Field and datapath widths
  localparam int unsigned CORE_W     = 7;
  localparam int unsigned MODE_W     = 3;
  localparam int unsigned MARGIN_W   = 7;
  localparam int unsigned TS_W       = 64;
  localparam int unsigned ACT_W      = 2;
  localparam int unsigned STAT_W     = 3;
  localparam int unsigned LOAD_W     = 13;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 7;
  localparam int unsigned WALL_DW    = 32;
  localparam int unsigned MUL_AW     = WALL_DW + CORE_W;
  localparam int unsigned MUL_BW     = CORE_W;
  localparam int unsigned PROD_W     = MUL_AW + MUL_BW;
  localparam int unsigned SUM_W      = MUL_AW + 1;
  localparam int unsigned QUO_W      = 14;
  localparam int unsigned DIVR_W     = WALL_DW + QUO_W - 1;
  localparam int unsigned DIV_CNT_W  = 4;
  localparam int unsigned THR_W      = 17;
  localparam int unsigned REQ_W      = 2;
  localparam int unsigned STEP_W     = 4;

  localparam int unsigned MAX_CORES_DEF = 64;
  localparam int unsigned MIN_SHIFT     = 4;

  localparam logic [MUL_BW-1:0]    PERCENT      = MUL_BW'(100);
  localparam logic [LOAD_W-1:0]    LOAD_SAT     = '1;
  localparam logic [DIV_CNT_W-1:0] DIV_TOP_BIT  = DIV_CNT_W'(QUO_W - 1);

  // Register reset values
  localparam logic [CORE_W-1:0]   CORE_LIMIT_RST = CORE_W'(64);
  localparam logic [CORE_W-1:0]   POSSIBLE_RST   = CORE_W'(64);
  localparam logic [MARGIN_W-1:0] INC_MARGIN_RST = MARGIN_W'(80);
  localparam logic [MARGIN_W-1:0] DEC_MARGIN_RST = MARGIN_W'(40);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLED    = 3'd0,
    REG_CORE_LIMIT = 3'd1,
    REG_POSSIBLE   = 3'd2,
    REG_MODE       = 3'd3,
    REG_INC_MARGIN = 3'd4,
    REG_DEC_MARGIN = 3'd5
  } reg_idx_e;

  typedef enum logic [MODE_W-1:0] {
    MODE_PERFORMANCE  = 3'd0,
    MODE_POWERSAVE    = 3'd1,
    MODE_ONDEMAND     = 3'd2,
    MODE_CONSERVATIVE = 3'd3,
    MODE_OTHER        = 3'd4
  } mode_e;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_UP   = 2'd1,
    ACT_DOWN = 2'd2
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_DISABLED  = 3'd0,
    ST_ABOVE_MAX = 3'd1,
    ST_BELOW_MIN = 3'd2,
    ST_INVALID   = 3'd3,
    ST_EVALUATED = 3'd4
  } status_e;

  typedef struct packed {
    logic                enabled;
    logic [CORE_W-1:0]   core_limit;
    logic [CORE_W-1:0]   possible_cores;
    logic [MODE_W-1:0]   governor_mode;
    logic [MARGIN_W-1:0] inc_margin;
    logic [MARGIN_W-1:0] dec_margin;
  } cfg_t;

  // Datapath micro-operations
  typedef enum logic [3:0] {
    UOP_NOP       = 4'd0,
    UOP_WINDOW    = 4'd1,
    UOP_CLASSIFY  = 4'd2,
    UOP_MUL_SPARE = 4'd3,
    UOP_MUL_CAP   = 4'd4,
    UOP_CHECK     = 4'd5,
    UOP_SCALE     = 4'd6,
    UOP_DIV       = 4'd7,
    UOP_THR_LO    = 4'd8,
    UOP_THR_HI    = 4'd9,
    UOP_DECIDE    = 4'd10,
    UOP_EMIT      = 4'd11
  } uop_e;

  // Sequencer jump conditions
  typedef enum logic [2:0] {
    JC_NEXT     = 3'd0,
    JC_IF_EARLY = 3'd1,
    JC_IF_BAD   = 3'd2,
    JC_IF_MORE  = 3'd3,
    JC_IF_HOLD  = 3'd4
  } jcond_e;

  typedef struct packed {
    uop_e              uop;
    jcond_e            cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic early_exit;
    logic bad_sample;
    logic div_more;
    logic out_busy;
  } flags_t;

  // Program step addresses
  localparam logic [STEP_W-1:0] STEP_FIRST = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd10;

  localparam ctrl_t CTRL_IDLE = '{uop: UOP_NOP, cond: JC_IF_HOLD, target: STEP_FIRST};

  // Microcode ROM: one control word per step
  function automatic ctrl_t chlg_ucode(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = CTRL_IDLE;
    unique case (step)
      4'd0:    w = '{uop: UOP_WINDOW,    cond: JC_NEXT,     target: STEP_FIRST};
      4'd1:    w = '{uop: UOP_CLASSIFY,  cond: JC_IF_EARLY, target: STEP_EMIT};
      4'd2:    w = '{uop: UOP_MUL_SPARE, cond: JC_NEXT,     target: STEP_FIRST};
      4'd3:    w = '{uop: UOP_MUL_CAP,   cond: JC_NEXT,     target: STEP_FIRST};
      4'd4:    w = '{uop: UOP_CHECK,     cond: JC_IF_BAD,   target: STEP_EMIT};
      4'd5:    w = '{uop: UOP_SCALE,     cond: JC_NEXT,     target: STEP_FIRST};
      4'd6:    w = '{uop: UOP_DIV,       cond: JC_IF_MORE,  target: STEP_DIV};
      4'd7:    w = '{uop: UOP_THR_LO,    cond: JC_NEXT,     target: STEP_FIRST};
      4'd8:    w = '{uop: UOP_THR_HI,    cond: JC_NEXT,     target: STEP_FIRST};
      4'd9:    w = '{uop: UOP_DECIDE,    cond: JC_NEXT,     target: STEP_FIRST};
      4'd10:   w = '{uop: UOP_EMIT,      cond: JC_IF_HOLD,  target: STEP_EMIT};
      default: w = CTRL_IDLE;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/chlg_sequencer.sv]
// Microcode sequencer: step counter, control ROM lookup and conditional jumps.
module chlg_sequencer
  import chlg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   start_i,
  input  flags_t flags_i,
  output logic   ready_o,
  output ctrl_t  ctrl_o
);

  logic              busy_q, busy_d;
  logic [STEP_W-1:0] pc_q, pc_d;
  logic [STEP_W-1:0] pc_inc;
  ctrl_t             word;

  // Fetch the control word of the current step
  assign word    = chlg_ucode(pc_q);
  assign ctrl_o  = busy_q ? word : CTRL_IDLE;
  assign ready_o = !busy_q;
  assign pc_inc  = pc_q + STEP_W'(1);

  // Select the next step
  always_comb begin
    busy_d = busy_q;
    pc_d   = pc_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d   = STEP_FIRST;
      end
    end else begin
      unique case (word.cond)
        JC_NEXT:     pc_d = pc_inc;
        JC_IF_EARLY: pc_d = flags_i.early_exit ? word.target : pc_inc;
        JC_IF_BAD:   pc_d = flags_i.bad_sample ? word.target : pc_inc;
        JC_IF_MORE:  pc_d = flags_i.div_more ? word.target : pc_inc;
        JC_IF_HOLD: begin
          if (flags_i.out_busy) begin
            pc_d = word.target;
          end else begin
            busy_d = 1'b0;
            pc_d   = STEP_FIRST;
          end
        end
        default: begin
          busy_d = 1'b0;
          pc_d   = STEP_FIRST;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= STEP_FIRST;
    end else begin
      busy_q <= busy_d;
      pc_q   <= pc_d;
    end
  end

  // A new word starts the program at its first step
  a_start_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_q |=> busy_q && pc_q == STEP_FIRST)
    else $error("program did not start at its first step");

  // An idle sequencer drives no datapath operation
  a_idle_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> ctrl_o.uop == UOP_NOP)
    else $error("datapath operation issued while idle");

  // Emitting into a free output register ends the program
  a_emit_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && word.cond == JC_IF_HOLD && !flags_i.out_busy |=> !busy_q)
    else $error("program did not end after emit");

endmodule

[rtl/core/chlg_datapath.sv]
// Governor datapath: window, deltas, shared multiplier, serial divider, decision, output register.
module chlg_datapath
  import chlg_pkg::*;
#(
  parameter int unsigned MAX_CORES = MAX_CORES_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  ctrl_t               ctrl_i,
  input  logic                in_load_i,
  input  logic [CORE_W-1:0]   online_cores_i,
  input  logic                sys_run_i,
  input  logic [TS_W-1:0]     idle_total_i,
  input  logic [TS_W-1:0]     wall_total_i,
  output flags_t              flags_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [ACT_W-1:0]    action_o,
  output logic [STAT_W-1:0]   status_o,
  output logic [LOAD_W-1:0]   load_percent_o
);

  // Sample registers
  logic [CORE_W-1:0] cur_q;
  logic              run_q;
  logic [TS_W-1:0]   idle_in_q, wall_in_q;
  logic [TS_W-1:0]   last_idle_q, last_wall_q;
  logic [REQ_W-1:0]  shrink_q, grow_q;

  // Window registers
  logic [CORE_W-1:0] all_q, max_q, min_q;
  logic [REQ_W-1:0]  grow_need_q, shrink_need_q;

  // Arithmetic registers
  logic [WALL_DW-1:0]   wall_d_q, idle_d_q;
  logic [PROD_W-1:0]    mul_q;
  logic [SUM_W-1:0]     idle_sum_q;
  logic [MUL_AW-1:0]    diff_q;
  logic [PROD_W-1:0]    rem_q;
  logic [DIVR_W-1:0]    div_q;
  logic [QUO_W-1:0]     quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic signed [THR_W-1:0] thr_lo_q, thr_hi_q;

  // Result and output registers
  logic [ACT_W-1:0]  res_action_q;
  logic [STAT_W-1:0] res_status_q;
  logic [LOAD_W-1:0] res_load_q;
  logic              out_valid_q;
  logic [ACT_W-1:0]  out_action_q;
  logic [STAT_W-1:0] out_status_q;
  logic [LOAD_W-1:0] out_load_q;

  // Window from configuration
  logic [CORE_W-1:0] all_w, lim_w, max_w, min_w;
  logic [REQ_W-1:0]  grow_need_w, shrink_need_w;

  always_comb begin
    all_w = (int'(cfg_i.possible_cores) > int'(MAX_CORES)) ? CORE_W'(MAX_CORES)
                                                            : cfg_i.possible_cores;
    lim_w = (cfg_i.core_limit > all_w) ? all_w : cfg_i.core_limit;
    max_w = lim_w;
    min_w = lim_w >> MIN_SHIFT;
    grow_need_w   = REQ_W'(1);
    shrink_need_w = REQ_W'(2);
    case (cfg_i.governor_mode)
      MODE_PERFORMANCE: min_w = lim_w;
      MODE_POWERSAVE:   max_w = lim_w >> MIN_SHIFT;
      MODE_ONDEMAND: begin
        grow_need_w   = REQ_W'(0);
        shrink_need_w = REQ_W'(2);
      end
      MODE_CONSERVATIVE: begin
        grow_need_w   = REQ_W'(1);
        shrink_need_w = REQ_W'(3);
      end
      default: ;
    endcase
  end

  // Classification of the sample against the window
  logic gate_off, above_max, below_min;
  assign gate_off  = !cfg_i.enabled || !run_q;
  assign above_max = cur_q > max_q;
  assign below_min = cur_q < min_q;

  // Shared multiplier
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;

  always_comb begin
    mul_a = MUL_AW'(wall_d_q);
    mul_b = all_q - cur_q;
    case (ctrl_i.uop)
      UOP_MUL_CAP: mul_b = all_q;
      UOP_SCALE: begin
        mul_a = diff_q;
        mul_b = PERCENT;
      end
      default: ;
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Sample check
  logic [SUM_W-1:0] cap_w;
  logic             bad_w;
  assign cap_w = SUM_W'(mul_q[MUL_AW-1:0]);
  assign bad_w = (wall_d_q == '0) || (cap_w < idle_sum_q);

  // Divider step
  logic             div_fit;
  logic [PROD_W-1:0] div_x;
  assign div_x   = PROD_W'(div_q);
  assign div_fit = rem_q >= div_x;

  // Threshold multiplier
  logic signed [THR_W-1:0] cm1, thr_b, thr_p;
  assign cm1   = $signed({{(THR_W-CORE_W){1'b0}}, cur_q}) - THR_W'(1);
  assign thr_b = (ctrl_i.uop == UOP_THR_HI)
               ? $signed(THR_W'(PERCENT))
               : $signed(THR_W'(PERCENT)) - $signed({{(THR_W-MARGIN_W){1'b0}}, cfg_i.dec_margin});
  assign thr_p = THR_W'(cm1 * thr_b);

  // Load comparison
  logic signed [THR_W-1:0] load_s;
  logic                    shrink_hit, grow_hit;
  assign load_s     = $signed({{(THR_W-QUO_W){1'b0}}, quo_q});
  assign shrink_hit = load_s < thr_lo_q;
  assign grow_hit   = load_s > thr_hi_q;

  logic out_busy;
  assign out_busy = out_valid_q && !out_ready_i;

  assign flags_o.early_exit = gate_off || above_max || below_min;
  assign flags_o.bad_sample = bad_w;
  assign flags_o.div_more   = cnt_q != '0;
  assign flags_o.out_busy   = out_busy;

  // Control state: sample history, request counters, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_idle_q <= '0;
      last_wall_q <= '0;
      shrink_q    <= '0;
      grow_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      unique case (ctrl_i.uop)
        UOP_CLASSIFY: begin
          if (!(gate_off || above_max || below_min)) begin
            last_idle_q <= idle_in_q;
            last_wall_q <= wall_in_q;
          end
        end
        UOP_DECIDE: begin
          if (shrink_hit) begin
            grow_q   <= '0;
            shrink_q <= (shrink_q < shrink_need_q) ? shrink_q + REQ_W'(1) : '0;
          end else begin
            shrink_q <= '0;
            if (grow_hit) begin
              grow_q <= (grow_q < grow_need_q) ? grow_q + REQ_W'(1) : '0;
            end
          end
        end
        default: ;
      endcase
      if (ctrl_i.uop == UOP_EMIT && !out_busy) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_load_i) begin
      cur_q     <= online_cores_i;
      run_q     <= sys_run_i;
      idle_in_q <= idle_total_i;
      wall_in_q <= wall_total_i;
    end
    unique case (ctrl_i.uop)
      UOP_WINDOW: begin
        all_q         <= all_w;
        max_q         <= max_w;
        min_q         <= min_w;
        grow_need_q   <= grow_need_w;
        shrink_need_q <= shrink_need_w;
      end
      UOP_CLASSIFY: begin
        res_load_q <= '0;
        wall_d_q   <= wall_in_q[WALL_DW-1:0] - last_wall_q[WALL_DW-1:0];
        idle_d_q   <= idle_in_q[WALL_DW-1:0] - last_idle_q[WALL_DW-1:0];
        if (gate_off) begin
          res_status_q <= ST_DISABLED;
          res_action_q <= ACT_NONE;
        end else if (above_max) begin
          res_status_q <= ST_ABOVE_MAX;
          res_action_q <= (cur_q != min_q) ? ACT_DOWN : ACT_NONE;
        end else if (below_min) begin
          res_status_q <= ST_BELOW_MIN;
          res_action_q <= (cur_q != max_q) ? ACT_UP : ACT_NONE;
        end
      end
      UOP_MUL_SPARE: mul_q <= mul_p;
      UOP_MUL_CAP: begin
        idle_sum_q <= SUM_W'(idle_d_q) + SUM_W'(mul_q[MUL_AW-1:0]);
        mul_q      <= mul_p;
      end
      UOP_CHECK: begin
        diff_q <= MUL_AW'(cap_w - idle_sum_q);
        if (bad_w) begin
          res_status_q <= ST_INVALID;
          res_action_q <= ACT_NONE;
        end
      end
      UOP_SCALE: begin
        rem_q <= mul_p;
        div_q <= {wall_d_q, {(QUO_W-1){1'b0}}};
        quo_q <= '0;
        cnt_q <= DIV_TOP_BIT;
      end
      UOP_DIV: begin
        if (div_fit) begin
          rem_q <= rem_q - div_x;
        end
        quo_q <= {quo_q[QUO_W-2:0], div_fit};
        div_q <= div_q >> 1;
        cnt_q <= cnt_q - DIV_CNT_W'(1);
      end
      UOP_THR_LO: thr_lo_q <= thr_p;
      UOP_THR_HI: thr_hi_q <= thr_p + $signed({{(THR_W-MARGIN_W){1'b0}}, cfg_i.inc_margin});
      UOP_DECIDE: begin
        res_status_q <= ST_EVALUATED;
        res_load_q   <= (quo_q > QUO_W'(LOAD_SAT)) ? LOAD_SAT : quo_q[LOAD_W-1:0];
        res_action_q <= ACT_NONE;
        if (shrink_hit) begin
          if (!(shrink_q < shrink_need_q) && cur_q != min_q) begin
            res_action_q <= ACT_DOWN;
          end
        end else if (grow_hit) begin
          if (!(grow_q < grow_need_q) && cur_q != max_q) begin
            res_action_q <= ACT_UP;
          end
        end
      end
      UOP_EMIT: begin
        if (!out_busy) begin
          out_action_q <= res_action_q;
          out_status_q <= res_status_q;
          out_load_q   <= res_load_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o    = out_valid_q;
  assign action_o       = out_action_q;
  assign status_o       = out_status_q;
  assign load_percent_o = out_load_q;

  // Only an evaluated word carries a load
  a_load_only_evaluated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_EVALUATED |-> out_load_q == '0)
    else $error("load reported without evaluation");

  // A count above the window always takes a core down
  a_above_takes_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_ABOVE_MAX |-> out_action_q == ACT_DOWN)
    else $error("above-max word without remove action");

  // Division leaves a remainder below the wall delta
  a_div_remainder: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.uop == UOP_DECIDE |-> rem_q < PROD_W'(wall_d_q))
    else $error("divider remainder out of range");

endmodule

[rtl/core/core_hotplug_load_governor.sv]
// Top level of the core hotplug load governor: ports, configuration registers, word packing.
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+--------------------------------------------
//  s_axis   | in        | tvalid / tready      | tdata: online_cores, idle_total, wall_total
//           |           |                      | tuser: running flag
//  m_axis   | out       | tvalid / tready      | tdata: action, status, load_percent
//  cfg      | in        | cfg_valid / cfg_ready| cfg_index_i, cfg_data_i
//
// The microcode program of a sample word jumps from classification to the emit step when
// disabled or outside the core window, from the sample check when the sample is invalid,
// and else runs its 14-step restoring divider. The input is ready again the cycle after the
// program ends. The result sits in an output register; the final step waits there while a
// previous result is not taken. Reset is asynchronous, active low, with no clearing pass;
// configuration writes are taken in every cycle.
module core_hotplug_load_governor
  import chlg_pkg::*;
#(
  parameter int unsigned MAX_CORES = MAX_CORES_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Sample input
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [6:0] online_cores, [70:7] idle_total, [134:71] wall_total, [135] zero
  input  logic [135:0]          s_axis_tdata,
  // [0] running flag
  input  logic                  s_axis_tuser,
  // Decision output
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [1:0] action, [4:2] status, [17:5] load_percent, [23:18] zero
  output logic [23:0]           m_axis_tdata,
  // Configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t   cfg_q;
  ctrl_t  ctrl;
  flags_t flags;
  logic   seq_ready;
  logic   in_accept;

  logic [ACT_W-1:0]  action;
  logic [STAT_W-1:0] status;
  logic [LOAD_W-1:0] load_percent;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = seq_ready;
  assign in_accept     = s_axis_tvalid && seq_ready;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enabled        <= 1'b0;
      cfg_q.core_limit     <= CORE_LIMIT_RST;
      cfg_q.possible_cores <= POSSIBLE_RST;
      cfg_q.governor_mode  <= MODE_OTHER;
      cfg_q.inc_margin     <= INC_MARGIN_RST;
      cfg_q.dec_margin     <= DEC_MARGIN_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENABLED:    cfg_q.enabled        <= cfg_data_i[0];
        REG_CORE_LIMIT: cfg_q.core_limit     <= cfg_data_i[CORE_W-1:0];
        REG_POSSIBLE:   cfg_q.possible_cores <= cfg_data_i[CORE_W-1:0];
        REG_MODE:       cfg_q.governor_mode  <= cfg_data_i[MODE_W-1:0];
        REG_INC_MARGIN: cfg_q.inc_margin     <= cfg_data_i[MARGIN_W-1:0];
        REG_DEC_MARGIN: cfg_q.dec_margin     <= cfg_data_i[MARGIN_W-1:0];
        default: ;
      endcase
    end
  end

  chlg_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (in_accept),
    .flags_i (flags),
    .ready_o (seq_ready),
    .ctrl_o  (ctrl)
  );

  chlg_datapath #(
    .MAX_CORES (MAX_CORES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg_q),
    .ctrl_i           (ctrl),
    .in_load_i        (in_accept),
    .online_cores_i   (s_axis_tdata[6:0]),
    .sys_run_i        (s_axis_tuser),
    .idle_total_i     (s_axis_tdata[70:7]),
    .wall_total_i     (s_axis_tdata[134:71]),
    .flags_o          (flags),
    .out_valid_o      (m_axis_tvalid),
    .out_ready_i      (m_axis_tready),
    .action_o         (action),
    .status_o         (status),
    .load_percent_o   (load_percent)
  );

  // Pack the result word
  assign m_axis_tdata = {6'b0, load_percent, status, action};

endmodule

[tb/tb_core_hotplug_load_governor.sv]
// Self-checking testbench for the core hotplug load governor.
`timescale 1ns / 100ps

module tb_core_hotplug_load_governor;
  import chlg_pkg::*;

  localparam int unsigned ITEMS         = 1850;
  localparam int unsigned CALM_ITEMS    = 1600;
  localparam int unsigned MIDWAY_PAUSE  = 1200;
  localparam int unsigned CALM_RESULTS  = 25 + CALM_ITEMS;
  localparam int unsigned LONG_HOLD_AT  = 600;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned STUCK_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned LOAD_CAP      = 8191;

  // Spare mode code, handled like the catch-all mode
  localparam logic [MODE_W-1:0] MODE_UNUSED_TOP = 3'd7;

  typedef struct {
    logic [CORE_W-1:0] online;
    logic              running;
    logic [TS_W-1:0]   idle;
    logic [TS_W-1:0]   wall;
  } tick_t;

  typedef struct {
    action_e           action;
    status_e           status;
    logic [LOAD_W-1:0] load;
  } verdict_t;

  typedef struct {
    bit                    is_cfg;
    reg_idx_e              idx;
    logic [CFG_DATA_W-1:0] val;
    tick_t                 tick;
    bit                    typed;
    verdict_t              want;
  } step_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [135:0]          s_axis_tdata  = '0;
  logic                  s_axis_tuser  = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  // Governor state as the block should hold it
  cfg_t            gov_cfg = '{enabled: 1'b0, core_limit: CORE_LIMIT_RST,
                               possible_cores: POSSIBLE_RST, governor_mode: MODE_OTHER,
                               inc_margin: INC_MARGIN_RST, dec_margin: DEC_MARGIN_RST};
  logic [TS_W-1:0] seen_wall  = '0;
  logic [TS_W-1:0] seen_idle  = '0;
  int              shrink_cnt = 0;
  int              grow_cnt   = 0;

  verdict_t pending_verdicts[$];
  int       mismatches    = 0;
  int       results_seen  = 0;
  int       stuck_cycles  = 0;
  int       trend         = 0;
  int       trend_left    = 0;
  int       tx_quiet_left = 0;

  core_hotplug_load_governor #(.MAX_CORES(MAX_CORES_DEF)) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  // Core window and request depths for the current configuration
  function automatic void core_window(output longint all_c, output longint maxc,
                                      output longint minc, output int grow_need,
                                      output int shrink_need);
    longint lim;
    all_c       = longint'(gov_cfg.possible_cores);
    lim         = longint'(gov_cfg.core_limit);
    grow_need   = 1;
    shrink_need = 2;
    if (all_c > longint'(MAX_CORES_DEF)) all_c = longint'(MAX_CORES_DEF);
    maxc = (lim > all_c) ? all_c : lim;
    minc = maxc / 16;
    case (gov_cfg.governor_mode)
      MODE_PERFORMANCE:  minc = maxc;
      MODE_POWERSAVE:    maxc = minc;
      MODE_ONDEMAND:     grow_need = 0;
      MODE_CONSERVATIVE: shrink_need = 3;
      default: ;
    endcase
  endfunction

  // Work out the decision for one tick and advance the governor state
  function automatic verdict_t governor_decide(tick_t t);
    verdict_t          v;
    longint            all_c, maxc, minc, cur, load, lo_thr, hi_thr;
    longint unsigned   wall_d, idle_d, cap, offline;
    logic [31:0]       wall32, idle32;
    int                grow_need, shrink_need;
    core_window(all_c, maxc, minc, grow_need, shrink_need);
    cur      = longint'(t.online);
    v.action = ACT_NONE;
    v.status = ST_DISABLED;
    v.load   = '0;
    if (!gov_cfg.enabled || !t.running) begin
      v.status = ST_DISABLED;
    end else if (cur > maxc) begin
      v.status = ST_ABOVE_MAX;
      if (cur != minc) v.action = ACT_DOWN;
    end else if (cur < minc) begin
      v.status = ST_BELOW_MIN;
      if (cur != maxc) v.action = ACT_UP;
    end else begin
      // deltas wrap at 32 bits; offline cores count as fully idle
      wall32    = t.wall[31:0] - seen_wall[31:0];
      idle32    = t.idle[31:0] - seen_idle[31:0];
      seen_wall = t.wall;
      seen_idle = t.idle;
      wall_d    = 64'(wall32);
      offline   = all_c - cur;
      idle_d    = 64'(idle32) + wall_d * offline;
      cap       = wall_d * all_c;
      if (wall_d == 0 || cap < idle_d) begin
        v.status = ST_INVALID;
      end else begin
        v.status = ST_EVALUATED;
        load     = longint'((64'd100 * (cap - idle_d)) / wall_d);
        lo_thr   = (cur - 1) * (100 - longint'(gov_cfg.dec_margin));
        hi_thr   = (cur - 1) * 100 + longint'(gov_cfg.inc_margin);
        if (load < lo_thr) begin
          grow_cnt = 0;
          if (shrink_cnt < shrink_need) begin
            shrink_cnt++;
          end else begin
            shrink_cnt = 0;
            if (cur != minc) v.action = ACT_DOWN;
          end
        end else begin
          shrink_cnt = 0;
          if (load > hi_thr) begin
            if (grow_cnt < grow_need) begin
              grow_cnt++;
            end else begin
              grow_cnt = 0;
              if (cur != maxc) v.action = ACT_UP;
            end
          end
        end
        v.load = (load > LOAD_CAP) ? LOAD_SAT : LOAD_W'(load);
      end
    end
    return v;
  endfunction

  // Empty table row
  function automatic step_t blank_step();
    step_t s;
    s.is_cfg = 1'b0;
    s.idx    = REG_ENABLED;
    s.val    = '0;
    s.tick   = '{online: '0, running: 1'b0, idle: '0, wall: '0};
    s.typed  = 1'b0;
    s.want   = '{action: ACT_NONE, status: ST_DISABLED, load: '0};
    return s;
  endfunction

  function automatic step_t reg_step(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    step_t s;
    s        = blank_step();
    s.is_cfg = 1'b1;
    s.idx    = idx;
    s.val    = val;
    return s;
  endfunction

  function automatic step_t tick_step(int online, int running, logic [TS_W-1:0] idle,
                                      logic [TS_W-1:0] wall);
    step_t s;
    s              = blank_step();
    s.tick.online  = CORE_W'(online);
    s.tick.running = (running != 0);
    s.tick.idle    = idle;
    s.tick.wall    = wall;
    return s;
  endfunction

  function automatic step_t typed_step(int online, int running, logic [TS_W-1:0] idle,
                                       logic [TS_W-1:0] wall, action_e a, status_e st);
    step_t s;
    s             = tick_step(online, running, idle, wall);
    s.typed       = 1'b1;
    s.want.action = a;
    s.want.status = st;
    s.want.load   = '0;
    return s;
  endfunction

  // Offer one sample word, hold it until taken, then queue its decision
  task automatic send_tick(input tick_t t, input bit typed, input verdict_t typed_want);
    verdict_t predicted;
    cfg_valid_i   <= 1'b0;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, t.wall, t.idle, t.online};
    s_axis_tuser  <= t.running;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = governor_decide(t);
    pending_verdicts.push_back(typed ? typed_want : predicted);
  endtask

  // Drop valid and wait until every queued decision has come out
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_ENABLED:    gov_cfg.enabled        = val[0];
      REG_CORE_LIMIT: gov_cfg.core_limit     = val;
      REG_POSSIBLE:   gov_cfg.possible_cores = val;
      REG_MODE:       gov_cfg.governor_mode  = val[MODE_W-1:0];
      REG_INC_MARGIN: gov_cfg.inc_margin     = val;
      REG_DEC_MARGIN: gov_cfg.dec_margin     = val;
      default: ;
    endcase
  endtask

  // Insert a random idle burst on the sample side now and then
  task automatic sender_gap();
    int coin;
    coin = $urandom_range(0, 99);
    if (tx_quiet_left != 0) begin
      tx_quiet_left--;
    end else if (coin < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end else if (coin < 18) begin
      tx_quiet_left = $urandom_range(10, 60);
    end
  endtask

  // Build a tick: mostly well-formed samples inside the window with loads held
  // in one band for a few ticks so the request counters run out
  task automatic make_tick(output tick_t t);
    longint          all_c, maxc, minc, cur, lo, hi, lo_end, hi_end, target, top;
    longint unsigned wall_d, idle_in;
    int              gn, sn, pick;
    core_window(all_c, maxc, minc, gn, sn);
    lo_end = (minc < 1) ? 1 : minc;
    hi_end = (maxc > 64) ? 64 : maxc;
    if (lo_end <= hi_end && $urandom_range(0, 99) < 85)
      cur = longint'($urandom_range(32'(hi_end), 32'(lo_end)));
    else
      cur = longint'($urandom_range(64, 1));
    t.online  = CORE_W'(cur);
    t.running = ($urandom_range(0, 99) >= 3);
    if (trend_left == 0) begin
      trend      = $urandom_range(0, 2);
      trend_left = $urandom_range(1, 6);
    end
    trend_left--;
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      wall_d  = 0;
      idle_in = 64'($urandom_range(3000, 0));
    end else if (pick < 12) begin
      wall_d  = 64'($urandom);
      idle_in = 64'($urandom);
    end else begin
      wall_d = 64'($urandom_range(32'd1 << $urandom_range(0, 25), 1));
      lo     = (cur - 1) * (100 - longint'(gov_cfg.dec_margin));
      hi     = (cur - 1) * 100 + longint'(gov_cfg.inc_margin);
      top    = 100 * cur;
      if (trend == 0 && lo > 0)
        target = longint'($urandom_range(32'(lo - 1), 0));
      else if (trend == 2 && hi < top)
        target = longint'($urandom_range(32'(top), 32'(hi + 1)));
      else
        target = longint'($urandom_range(32'((hi < top) ? hi : top), 32'((lo > 0) ? lo : 0)));
      idle_in = wall_d * cur - (wall_d * target) / 100;
      // idle above what the online cores could log
      if (pick < 15) idle_in = wall_d * cur + 64'($urandom_range(5000, 1));
    end
    t.wall = seen_wall + wall_d;
    t.idle = seen_idle + idle_in;
    // upper halves do not enter the deltas
    if ($urandom_range(0, 99) < 20) t.wall[63:32] = $urandom;
    if ($urandom_range(0, 99) < 20) t.idle[63:32] = $urandom;
  endtask

  // Set up one random phase; the first two take the margin extremes
  task automatic phase_config(int ph);
    logic [CFG_DATA_W-1:0] v [6];
    drain();
    if (ph == 0) begin
      v = '{7'd1, 7'd64, 7'd64, 7'(MODE_ONDEMAND), 7'd0, 7'd0};
    end else if (ph == 1) begin
      v = '{7'd1, 7'd64, 7'd64, 7'(MODE_CONSERVATIVE), 7'd100, 7'd100};
    end else begin
      v[REG_ENABLED]    = CFG_DATA_W'($urandom_range(0, 9) != 0);
      v[REG_CORE_LIMIT] = CFG_DATA_W'(($urandom_range(0, 4) != 0) ? $urandom_range(64, 16)
                                                                  : $urandom_range(127, 0));
      v[REG_POSSIBLE]   = CFG_DATA_W'(($urandom_range(0, 4) != 0) ? $urandom_range(64, 16)
                                                                  : $urandom_range(127, 0));
      v[REG_MODE]       = CFG_DATA_W'(($urandom_range(0, 6) != 0)
                                      ? $urandom_range(MODE_OTHER, 0)
                                      : $urandom_range(MODE_UNUSED_TOP, 0));
      v[REG_INC_MARGIN] = CFG_DATA_W'(($urandom_range(0, 6) != 0) ? $urandom_range(100, 0)
                                                                  : $urandom_range(127, 101));
      v[REG_DEC_MARGIN] = CFG_DATA_W'(($urandom_range(0, 6) != 0) ? $urandom_range(100, 0)
                                                                  : $urandom_range(127, 101));
    end
    for (int i = 0; i < 6; i++) write_reg(reg_idx_e'(i), v[i]);
  endtask

  // Check each result word and pace the result side
  always @(posedge clk_i) begin : sink
    verdict_t want;
    int       hold_left;
    int       quiet_left;
    bit       long_hold_done;
    int       coin;
    if (m_axis_tvalid && m_axis_tready) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result word %h", $time, m_axis_tdata);
      end else begin
        want = pending_verdicts.pop_front();
        if (m_axis_tdata[1:0] !== want.action || m_axis_tdata[4:2] !== want.status ||
            m_axis_tdata[17:5] !== want.load) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d expected action %0d status %0d load %0d, %s %0d %0d %0d",
                     $time, results_seen, want.action, want.status, want.load, "got",
                     m_axis_tdata[1:0], m_axis_tdata[4:2], m_axis_tdata[17:5]);
        end
      end
    end
    coin = $urandom_range(0, 99);
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LONG_HOLD_AT) begin
      // long back-pressure so the block fills up and stalls its input
      long_hold_done = 1'b1;
      hold_left      = LONG_HOLD - 1;
      m_axis_tready <= 1'b0;
    end else if (quiet_left != 0 || results_seen >= CALM_RESULTS) begin
      if (quiet_left != 0) quiet_left--;
      m_axis_tready <= 1'b1;
    end else if (coin < 6) begin
      hold_left = $urandom_range(16, 1) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      if (coin < 8) quiet_left = $urandom_range(300, 50);
      m_axis_tready <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    step_t    plan[$];
    tick_t    t;
    verdict_t unused_want;
    int       random_items;
    int       ph;
    int       phase_len;

    unused_want = '{action: ACT_NONE, status: ST_DISABLED, load: '0};

    // Directed part: reset values, bounds, counters, wrap and the odd registers
    plan.push_back(typed_step(4, 1, 64'd0, 64'd100, ACT_NONE, ST_DISABLED));
    plan.push_back(reg_step(REG_ENABLED, 7'd1));
    plan.push_back(typed_step(4, 0, 64'd0, 64'd100, ACT_NONE, ST_DISABLED));
    plan.push_back(tick_step(64, 1, 64'd0, 64'd1000));   // full load, first grow request
    plan.push_back(tick_step(64, 1, 64'd0, 64'd2000));   // grow at the top of the window
    plan.push_back(typed_step(64, 1, 64'd0, 64'd2000, ACT_NONE, ST_INVALID));
    plan.push_back(typed_step(2, 1, 64'd0, 64'd3000, ACT_UP, ST_BELOW_MIN));
    plan.push_back(typed_step(4, 1, 64'd4001, 64'd3000, ACT_NONE, ST_INVALID));
    plan.push_back(tick_step(4, 1, 64'd8001, 64'd4000));  // zero load
    plan.push_back(tick_step(4, 1, 64'd12001, 64'd5000));
    plan.push_back(tick_step(4, 1, 64'd16001, 64'd6000)); // shrink at the bottom
    plan.push_back(tick_step(4, 1, 64'hFFFF_FFFF_0000_3E81, 64'hFFFF_FFFF_FFFF_FFF0));
    plan.push_back(tick_step(4, 1, 64'd16001, 64'd16));   // wall wraps
    plan.push_back(reg_step(REG_CORE_LIMIT, 7'd0));
    plan.push_back(typed_step(1, 1, 64'd16001, 64'd116, ACT_DOWN, ST_ABOVE_MAX));
    plan.push_back(reg_step(REG_CORE_LIMIT, 7'd127));
    plan.push_back(reg_step(REG_POSSIBLE, 7'd127));
    plan.push_back(tick_step(64, 1, 64'd16001, 64'd116)); // core count clamped
    plan.push_back(reg_step(REG_MODE, 7'(MODE_ONDEMAND)));
    plan.push_back(tick_step(10, 1, 64'd16001, 64'd216));
    plan.push_back(reg_step(REG_MODE, 7'(MODE_PERFORMANCE)));
    plan.push_back(typed_step(10, 1, 64'd16001, 64'd316, ACT_UP, ST_BELOW_MIN));
    plan.push_back(reg_step(REG_MODE, 7'(MODE_POWERSAVE)));
    plan.push_back(typed_step(10, 1, 64'd16001, 64'd316, ACT_DOWN, ST_ABOVE_MAX));
    plan.push_back(reg_step(REG_MODE, 7'(MODE_CONSERVATIVE)));
    plan.push_back(reg_step(REG_DEC_MARGIN, 7'd127));     // negative shrink threshold
    plan.push_back(reg_step(REG_INC_MARGIN, 7'd127));
    plan.push_back(tick_step(10, 1, 64'd17001, 64'd316));
    plan.push_back(reg_step(REG_DEC_MARGIN, 7'd0));
    plan.push_back(reg_step(REG_INC_MARGIN, 7'd100));
    plan.push_back(tick_step(10, 1, 64'd17501, 64'd416));
    plan.push_back(tick_step(10, 1, 64'd18001, 64'd516));
    plan.push_back(tick_step(10, 1, 64'd18501, 64'd616));
    plan.push_back(tick_step(10, 1, 64'd19001, 64'd716));
    plan.push_back(reg_step(REG_MODE, 7'(MODE_UNUSED_TOP)));
    plan.push_back(reg_step(REG_INC_MARGIN, 7'd50));
    plan.push_back(tick_step(10, 1, 64'd19001, 64'd816));
    plan.push_back(tick_step(10, 1, 64'd19001, 64'd916));
    plan.push_back(typed_step(10, 0, 64'd19001, 64'd1016, ACT_NONE, ST_DISABLED));

    // Hold reset, then release it on a clock edge
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) begin
        drain();
        write_reg(plan[i].idx, plan[i].val);
      end else begin
        send_tick(plan[i].tick, plan[i].typed, plan[i].want);
        sender_gap();
      end
    end

    // Random part, one configuration per phase
    random_items = 0;
    ph           = 0;
    while (random_items < ITEMS) begin
      phase_config(ph);
      phase_len = $urandom_range(200, 100);
      for (int k = 0; k < phase_len && random_items < ITEMS; k++) begin
        make_tick(t);
        send_tick(t, 1'b0, unused_want);
        random_items++;
        if (random_items == MIDWAY_PAUSE)
          drain();
        else if (random_items < CALM_ITEMS)
          sender_gap();
      end
      ph++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
